@@ sv/sajd_pkg.sv @@
// Package for the set assignment Jaccard distance unit.
// Holds sizes, command codes, controller states and the control struct.
// Used by all modules of the unit; depends on nothing.
`timescale 1ns / 1ps
package sajd_pkg;
   localparam int MaxSets   = 8;
   localparam int NodeCount = 256;
   localparam int FracBits  = 16;
   localparam int Words     = (NodeCount + 63) / 64;
   localparam int Masks     = 1 << MaxSets;
   localparam int SetW      = $clog2(MaxSets);
   localparam int WordW     = (Words > 1) ? $clog2(Words) : 1;
   localparam int CntW      = $clog2(NodeCount + 1);
   localparam int CostW     = 17;
   localparam int DistW     = 20;
   localparam int QuotW     = FracBits + 1;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_ADD     = 2'd1,
      CMD_COMPUTE = 2'd2,
      CMD_NONE    = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_POP_RD,
      ST_POP_ACC,
      ST_DIV_INIT,
      ST_DIV,
      ST_DIV_WR,
      ST_DP_INIT,
      ST_DP_RD,
      ST_DP_ACC,
      ST_DP_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       clr_step;
      logic       pop_read;
      logic       pop_acc;
      logic       div_init;
      logic       div_step;
      logic       cost_write;
      logic       dp_init;
      logic       dp_read;
      logic       dp_acc;
      logic       dp_write;
      logic       emit;
   } ctrl_type;

   typedef struct packed {
      logic       clr_last;
      logic       word_last;
      logic       pair_last;
      logic       div_last;
      logic       bit_last;
      logic       mask_last;
      logic       zero_count;
   } stat_type;
endpackage

@@ sv/set_assignment_jaccard_distance_unit.sv @@
// Top level of the set assignment Jaccard distance unit.
// Joins sajd_controller and sajd_datapath and holds the drone count register.
// Depends on sajd_pkg, sajd_controller and sajd_datapath.
`timescale 1ns / 1ps
// Commands are taken while busy is low. After reset the unit clears its bitmaps
// with busy high. Clear sweeps the 32 bitmap words. A compute walks m*m set
// pairs (popcount per word, then a 25-step restoring divide), then the 2^m - 1
// masks of the dynamic program. The drone count is written only while busy is low.
// The result shows on rsp_distance for one cycle under rsp_valid; the
// receiver cannot stall it.
module set_assignment_jaccard_distance_unit
   import sajd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic              req_side,
   input  logic [2:0]        req_drone,
   input  logic [7:0]        req_node,
   output logic              rsp_valid,
   output logic [DistW-1:0]  rsp_distance,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_set_count
);
   ctrl_type   ctrl;
   stat_type   stat;
   logic       add_en;
   logic [3:0] count_ff;

   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_set_count;
      end
   end

   sajd_controller u_ctrl (
      .clock, .reset, .start, .req_command, .stat, .ctrl, .busy, .add_en, .rsp_valid
   );

   sajd_datapath u_dp (
      .clock, .reset, .ctrl, .stat, .add_en, .req_side, .req_drone, .req_node,
      .set_count(count_ff), .result(rsp_distance)
   );
endmodule

@@ sv/sajd_datapath.sv @@
// Datapath of the set assignment Jaccard distance unit.
// Set bitmap, cost and table memories, popcount, restoring divider and DP adder.
// Depends on sajd_pkg.
`timescale 1ns / 1ps
module sajd_datapath
   import sajd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_type             ctrl,
   output stat_type             stat,
   input  logic                 add_en,
   input  logic                 req_side,
   input  logic [2:0]           req_drone,
   input  logic [7:0]           req_node,
   input  logic [3:0]           set_count,
   output logic [DistW-1:0]     result
);
   localparam int SetsW = SetW + WordW;
   localparam int AddrW = SetW + SetW;

   logic [63:0]          mem_a [MaxSets*Words];
   logic [63:0]          mem_b [MaxSets*Words];
   logic [CostW-1:0]     cost_mem [MaxSets*MaxSets];
   logic [DistW-1:0]     best_mem [Masks];

   logic [SetW:0]        m;
   logic [SetsW-1:0]     clr_ff, clr_in;
   logic [SetW-1:0]      ia_ff, ia_in, ib_ff, ib_in;
   logic [WordW-1:0]     w_ff, w_in;
   logic [63:0]          xa_ff, xb_ff;
   logic [CntW-1:0]      inter_ff, inter_in, uni_ff, uni_in;
   logic [CntW+FracBits-1:0] num_ff, num_in;
   logic [CntW:0]        rem_ff, rem_in;
   logic [QuotW-1:0]     quo_ff, quo_in;
   logic [$clog2(CntW+FracBits+1)-1:0] dcnt_ff, dcnt_in;
   logic [MaxSets-1:0]   mask_ff, mask_in;
   logic [SetW-1:0]      j_ff, j_in;
   logic [SetW-1:0]      row_ff;
   logic [DistW:0]       best_ff, best_in;
   logic [DistW-1:0]     prev_ff;
   logic [CostW-1:0]     cost_ff;
   logic                 take_ff;
   logic [DistW-1:0]     result_ff, result_in;
   logic [MaxSets-1:0]   full;
   logic [CntW:0]        trial;
   logic [MaxSets-1:0]   pmask;

   assign m    = (set_count > 4'(MaxSets)) ? (SetW+1)'(MaxSets) : set_count[SetW:0];
   assign full = MaxSets'((1 << m) - 1);
   assign pmask = mask_ff ^ (MaxSets'(1) << j_ff);

   always_ff @(posedge clock) begin
      if (ctrl.clr_step) begin
         mem_a[clr_ff] <= '0;
         mem_b[clr_ff] <= '0;
      end else if (add_en) begin
         if (req_side == 1'b0) begin
            mem_a[{req_drone[SetW-1:0], req_node[7:6]}] <=
               mem_a[{req_drone[SetW-1:0], req_node[7:6]}] | (64'd1 << req_node[5:0]);
         end else begin
            mem_b[{req_drone[SetW-1:0], req_node[7:6]}] <=
               mem_b[{req_drone[SetW-1:0], req_node[7:6]}] | (64'd1 << req_node[5:0]);
         end
      end
      if (ctrl.pop_read) begin
         xa_ff <= mem_a[{ia_ff, w_ff}];
         xb_ff <= mem_b[{ib_ff, w_ff}];
      end
      if (ctrl.cost_write) begin
         cost_mem[AddrW'({ia_ff, ib_ff})] <= (uni_ff == '0) ? '0 : CostW'(quo_ff);
      end
      if (ctrl.dp_read) begin
         prev_ff <= best_mem[pmask];
         cost_ff <= cost_mem[AddrW'({row_ff, j_ff})];
         take_ff <= mask_ff[j_ff];
      end
      if (ctrl.dp_init) begin
         best_mem[0] <= '0;
      end else if (ctrl.dp_write) begin
         best_mem[mask_ff] <= best_ff[DistW-1:0];
      end
   end

   always_comb begin
      clr_in   = clr_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      w_in     = w_ff;
      inter_in = inter_ff;
      uni_in   = uni_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dcnt_in  = dcnt_ff;
      mask_in  = mask_ff;
      j_in     = j_ff;
      best_in  = best_ff;
      result_in = result_ff;
      trial    = {rem_ff[CntW-1:0], num_ff[CntW+FracBits-1]} - {1'b0, uni_ff};
      if (ctrl.clr_step) begin
         clr_in = clr_ff + SetsW'(1);
      end
      if (ctrl.pop_acc) begin
         inter_in = inter_ff + CntW'($countones(xa_ff & xb_ff));
         uni_in   = uni_ff + CntW'($countones(xa_ff | xb_ff));
         w_in     = w_ff + WordW'(1);
      end
      if (ctrl.div_init) begin
         num_in  = (CntW+FracBits)'(uni_ff - inter_ff) << FracBits;
         rem_in  = '0;
         quo_in  = '0;
         dcnt_in = '0;
      end
      if (ctrl.div_step) begin
         num_in  = num_ff << 1;
         dcnt_in = dcnt_ff + 1'b1;
         if (!trial[CntW]) begin
            rem_in = trial;
            quo_in = {quo_ff[QuotW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[CntW-1:0], num_ff[CntW+FracBits-1]};
            quo_in = {quo_ff[QuotW-2:0], 1'b0};
         end
      end
      if (ctrl.cost_write) begin
         inter_in = '0;
         uni_in   = '0;
         w_in     = '0;
         if (ib_ff == SetW'(m - 1'b1)) begin
            ib_in = '0;
            ia_in = ia_ff + SetW'(1);
         end else begin
            ib_in = ib_ff + SetW'(1);
         end
      end
      if (ctrl.dp_init) begin
         mask_in  = MaxSets'(1);
         j_in     = '0;
         best_in  = '1;
      end
      if (ctrl.dp_acc) begin
         if (take_ff && ({1'b0, prev_ff} + (DistW+1)'(cost_ff) < best_ff)) begin
            best_in = {1'b0, prev_ff} + (DistW+1)'(cost_ff);
         end
         j_in = j_ff + SetW'(1);
      end
      if (ctrl.dp_write) begin
         mask_in = mask_ff + 1'b1;
         j_in    = '0;
         best_in = '1;
         if (mask_ff == full) begin
            result_in = best_ff[DistW-1:0];
         end
      end
      if (ctrl.emit && m == '0) begin
         result_in = '0;
      end
      if (ctrl.pop_read && ia_ff == '0 && ib_ff == '0 && w_ff == '0) begin
         result_in = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         ia_ff    <= '0;
         ib_ff    <= '0;
         w_ff     <= '0;
         inter_ff <= '0;
         uni_ff   <= '0;
      end else begin
         clr_ff   <= clr_in;
         ia_ff    <= (ctrl.dp_init) ? '0 : ia_in;
         ib_ff    <= (ctrl.dp_init) ? '0 : ib_in;
         w_ff     <= w_in;
         inter_ff <= inter_in;
         uni_ff   <= uni_in;
      end
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      mask_ff   <= mask_in;
      j_ff      <= j_in;
      best_ff   <= best_in;
      result_ff <= result_in;
      row_ff    <= SetW'($countones(mask_in) - 1);
   end

   assign stat.clr_last   = (clr_ff == SetsW'(MaxSets*Words - 1));
   assign stat.word_last  = (w_ff == WordW'(Words - 1));
   assign stat.pair_last  = (ia_ff == SetW'(m - 1'b1)) && (ib_ff == SetW'(m - 1'b1));
   assign stat.div_last   = (dcnt_ff == ($bits(dcnt_ff))'(CntW + FracBits - 1));
   assign stat.bit_last   = (j_ff == SetW'(m - 1'b1));
   assign stat.mask_last  = (mask_ff == full);
   assign stat.zero_count = (m == '0);
   assign result = (m == '0) ? '0 : result_ff;
endmodule

@@ sv/sajd_controller.sv @@
// Controller state machine of the set assignment Jaccard distance unit.
// Sequences clear sweeps, pair cost evaluation and the mask dynamic program.
// Depends on sajd_pkg.
`timescale 1ns / 1ps
module sajd_controller
   import sajd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_command,
   input  stat_type    stat,
   output ctrl_type    ctrl,
   output logic        busy,
   output logic        add_en,
   output logic        rsp_valid
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (req_command == CMD_COMPUTE) begin
                  state_in = ST_POP_RD;
                  if (stat.zero_count) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_CLEAR:    if (stat.clr_last) state_in = ST_IDLE;
         ST_POP_RD:   state_in = ST_POP_ACC;
         ST_POP_ACC:  state_in = stat.word_last ? ST_DIV_INIT : ST_POP_RD;
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV:      if (stat.div_last) state_in = ST_DIV_WR;
         ST_DIV_WR:   state_in = stat.pair_last ? ST_DP_INIT : ST_POP_RD;
         ST_DP_INIT:  state_in = ST_DP_RD;
         ST_DP_RD:    state_in = ST_DP_ACC;
         ST_DP_ACC:   state_in = stat.bit_last ? ST_DP_WR : ST_DP_RD;
         ST_DP_WR:    state_in = stat.mask_last ? ST_DONE : ST_DP_RD;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_CLEAR:    ctrl.clr_step   = 1'b1;
         ST_POP_RD:   ctrl.pop_read   = 1'b1;
         ST_POP_ACC:  ctrl.pop_acc    = 1'b1;
         ST_DIV_INIT: ctrl.div_init   = 1'b1;
         ST_DIV:      ctrl.div_step   = 1'b1;
         ST_DIV_WR:   ctrl.cost_write = 1'b1;
         ST_DP_INIT:  ctrl.dp_init    = 1'b1;
         ST_DP_RD:    ctrl.dp_read    = 1'b1;
         ST_DP_ACC:   ctrl.dp_acc     = 1'b1;
         ST_DP_WR:    ctrl.dp_write   = 1'b1;
         ST_DONE:     ctrl.emit       = 1'b1;
         default:     ctrl = '0;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign add_en    = start && !busy && (req_command == CMD_ADD);
   assign rsp_valid = (state_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_CLEAR) |=> busy)
      else $error("clear did not start sweep");
   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("not idle after result");
   a_add_idle: assert property (@(posedge clock) disable iff (reset)
      add_en |=> !busy)
      else $error("add made unit busy");
endmodule

@@ sim/tb_set_assignment_jaccard_distance_unit.sv @@
// Testbench for the set assignment Jaccard distance unit.
// Loads node sets, computes minimum-cost matchings and checks each distance
// against an in-bench predictor. Depends on sajd_pkg and the unit's top level.
`timescale 1ns / 1ps
module tb_set_assignment_jaccard_distance_unit;
   import sajd_pkg::*;

   typedef struct {
      command_type command;
      logic        side;
      logic [2:0]  drone;
      logic [7:0]  node;
      logic        known;
      logic [19:0] distance;
   } row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_command;
   logic              req_side;
   logic [2:0]        req_drone;
   logic [7:0]        req_node;
   logic              rsp_valid;
   logic [DistW-1:0]  rsp_distance;
   logic              csr_valid;
   logic              csr_ready;
   logic [3:0]        csr_set_count;

   logic [NodeCount-1:0] family_a [MaxSets];
   logic [NodeCount-1:0] family_b [MaxSets];
   logic [3:0]           model_count;
   logic [19:0]          pending_distance [$];
   int                   mismatch_count;
   int                   result_count;
   bit                   quiet;
   row_type              steps [$];

   set_assignment_jaccard_distance_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_side(req_side), .req_drone(req_drone),
      .req_node(req_node), .rsp_valid(rsp_valid), .rsp_distance(rsp_distance),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_set_count(csr_set_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Run timed out.");
      $display("FAILURE");
      $finish;
   end

   function automatic logic [16:0] jaccard_cost(int ia, int ib);
      int both;
      int either;
      logic [63:0] num;
      both = $countones(family_a[ia] & family_b[ib]);
      either = $countones(family_a[ia] | family_b[ib]);
      if (either == 0) return 17'd0;
      num = 64'(either - both) << FracBits;
      return 17'(num / either);
   endfunction

   function automatic logic [19:0] best_matching();
      int m;
      int row;
      logic [16:0] cost [MaxSets][MaxSets];
      logic [19:0] best [Masks];
      logic [63:0] cand;
      logic [63:0] low;
      m = (model_count > MaxSets) ? MaxSets : int'(model_count);
      if (m == 0) return 20'd0;
      for (int i = 0; i < m; i++)
         for (int j = 0; j < m; j++)
            cost[i][j] = jaccard_cost(i, j);
      best[0] = 20'd0;
      for (int mask = 1; mask < (1 << m); mask++) begin
         row = $countones(mask) - 1;
         low = '1;
         for (int j = 0; j < m; j++)
            if (mask[j]) begin
               cand = 64'(best[mask ^ (1 << j)]) + 64'(cost[row][j]);
               if (cand < low) low = cand;
            end
         best[mask] = low[19:0];
      end
      return best[(1 << m) - 1];
   endfunction

   task automatic apply_item(row_type r);
      start       <= 1'b1;
      req_command <= r.command;
      req_side    <= r.side;
      req_drone   <= r.drone;
      req_node    <= r.node;
      do @(posedge clock); while (busy);
      case (r.command)
         CMD_CLEAR: begin
            for (int i = 0; i < MaxSets; i++) begin
               family_a[i] = '0;
               family_b[i] = '0;
            end
         end
         CMD_ADD: begin
            if (r.side) family_b[r.drone][r.node] = 1'b1;
            else family_a[r.drone][r.node] = 1'b1;
         end
         CMD_COMPUTE: begin
            if (r.known && best_matching() != r.distance)
               $display("Table row disagrees with predictor: %0d vs %0d",
                        r.distance, best_matching());
            pending_distance = {pending_distance,
                                (r.known ? r.distance : best_matching())};
         end
         default: ;
      endcase
      if (!quiet && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_count(logic [3:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (pending_distance.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_set_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      model_count = value;
   endtask

   function automatic row_type make_row(command_type c, logic s, logic [2:0] d,
                                        logic [7:0] n);
      row_type r;
      r.command = c; r.side = s; r.drone = d; r.node = n;
      r.known = 1'b0; r.distance = '0;
      return r;
   endfunction

   task automatic load_random_sets(int m);
      apply_item(make_row(CMD_CLEAR, 1'($urandom), 3'($urandom), 8'($urandom)));
      for (int k = $urandom_range(0, 3 * m); k > 0; k--)
         apply_item(make_row(CMD_ADD, 1'($urandom),
                             3'($urandom_range(0, m > 0 ? m - 1 : 7)),
                             8'($urandom_range(1) ? $urandom_range(0, 15) : $urandom)));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         result_count <= result_count + 1;
         if (pending_distance.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("Unexpected distance transfer %0d", rsp_distance);
         end else begin
            if (rsp_distance !== pending_distance[0]) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("Distance mismatch: expected %0d, actual %0d",
                           pending_distance[0], rsp_distance);
            end
            void'(pending_distance.pop_front());
         end
      end
   end

   initial begin
      row_type r;
      int      wait_cycles;
      logic [3:0] counts [6];
      counts = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd3, 4'd5};
      mismatch_count = 0;
      result_count = 0;
      quiet = 1'b0;
      model_count = '0;
      for (int i = 0; i < MaxSets; i++) begin
         family_a[i] = '0;
         family_b[i] = '0;
      end
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_CLEAR;
      req_side = 1'b0;
      req_drone = '0;
      req_node = '0;
      csr_valid = 1'b0;
      csr_set_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      r = make_row(CMD_COMPUTE, 1'b1, 3'd7, 8'd255); r.known = 1'b1; steps = {steps, r};
      steps = {steps, make_row(CMD_NONE, 1'b1, 3'd7, 8'd255)};
      steps = {steps, make_row(CMD_ADD, 1'b0, 3'd0, 8'd0)};
      r = make_row(CMD_COMPUTE, 1'b0, 3'd0, 8'd0); r.known = 1'b1; steps = {steps, r};
      foreach (steps[i]) apply_item(steps[i]);
      steps.delete();
      write_count(4'd1);
      r = make_row(CMD_COMPUTE, 1'b0, 3'd0, 8'd0); r.known = 1'b1; r.distance = 20'd65536;
      steps = {steps, r};
      steps = {steps, make_row(CMD_ADD, 1'b1, 3'd0, 8'd0)};
      r = make_row(CMD_COMPUTE, 1'b0, 3'd0, 8'd0); r.known = 1'b1; r.distance = 20'd0;
      steps = {steps, r};
      steps = {steps, make_row(CMD_ADD, 1'b1, 3'd7, 8'd255)};
      steps = {steps, make_row(CMD_ADD, 1'b0, 3'd7, 8'd170)};
      steps = {steps, make_row(CMD_ADD, 1'b1, 3'd0, 8'd85)};
      steps = {steps, make_row(CMD_COMPUTE, 1'b1, 3'd7, 8'd255)};
      steps = {steps, make_row(CMD_CLEAR, 1'b1, 3'd7, 8'd255)};
      r = make_row(CMD_COMPUTE, 1'b0, 3'd0, 8'd0); r.known = 1'b1; r.distance = 20'd0;
      steps = {steps, r};
      foreach (steps[i]) apply_item(steps[i]);
      write_count(4'd8);
      for (int d = 0; d < 8; d++) begin
         apply_item(make_row(CMD_ADD, 1'b0, 3'(d), 8'(d)));
         apply_item(make_row(CMD_ADD, 1'b1, 3'(d), 8'(255 - d)));
      end
      r = make_row(CMD_COMPUTE, 1'b0, 3'd0, 8'd0); r.known = 1'b1; r.distance = 20'd524288;
      apply_item(r);

      for (int phase = 0; phase < 6; phase++) begin
         write_count(counts[phase]);
         if (phase == 5) quiet = 1'b1;
         for (int k = 0; k < 4; k++) begin
            load_random_sets(counts[phase] > 8 ? 8 : counts[phase]);
            if ($urandom_range(4) == 0)
               apply_item(make_row(CMD_NONE, 1'($urandom), 3'($urandom), 8'($urandom)));
            apply_item(make_row(CMD_COMPUTE, 1'($urandom), 3'($urandom), 8'($urandom)));
         end
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (pending_distance.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      $display("Checked %0d distance transfers over drone counts 0, 1, 3, 5, 8 and 15.",
               result_count);
      if (mismatch_count == 0 && pending_distance.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results missing.", mismatch_count,
                  pending_distance.size());
         $display("FAILURE");
      end
      $finish;
   end
endmodule
